FILE: design/csvp_pkg.sv
// Package for the comma-separated paper record parser.
// Holds result kind codes, field position codes and character constants.
// Depends on nothing; every other file of the block imports it.
package csvp_pkg;

    localparam int DIGIT_BITS = 4;
    localparam int FIELD_BITS = 3;
    localparam int RADIX = 10;

    typedef logic [1:0] kind_t;
    typedef logic [FIELD_BITS-1:0] field_t;

    localparam kind_t KIND_TITLE   = 2'd0;
    localparam kind_t KIND_KEYWORD = 2'd1;
    localparam kind_t KIND_RECORD  = 2'd2;
    localparam kind_t KIND_ERROR   = 2'd3;

    localparam field_t FIELD_ID         = 3'd0;
    localparam field_t FIELD_TITLE      = 3'd1;
    localparam field_t FIELD_YEAR       = 3'd2;
    localparam field_t FIELD_CONFERENCE = 3'd3;
    localparam field_t FIELD_JOURNAL    = 3'd4;
    localparam field_t FIELD_KEYWORDS   = 3'd5;

    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TILDE   = 8'd126;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  text_byte;
        logic [31:0] record_id;
        logic [31:0] pub_year;
        logic [31:0] conference_number;
        logic [31:0] journal_number;
    } result_t;

endpackage

FILE: design/csvp_if.sv
// Valid/ready channel interfaces of the paper record parser.
// csvp_byte_if carries one text byte, csvp_result_if one parse result.
// Depends on csvp_pkg for the kind type.
interface csvp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface csvp_result_if import csvp_pkg::*;;
    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [7:0]  text_byte;
    logic [31:0] record_id;
    logic [31:0] pub_year;
    logic [31:0] conference_number;
    logic [31:0] journal_number;

    modport source (output valid, output kind, output text_byte, output record_id,
                    output pub_year, output conference_number, output journal_number,
                    input ready);
    modport sink (input valid, input kind, input text_byte, input record_id,
                  input pub_year, input conference_number, input journal_number,
                  output ready);
endinterface

FILE: design/csv_paper_record_parser.sv
// Top level of the comma-separated paper record parser.
// Depends on csvp_pkg, csvp_if.sv and csvp_digit_acc.
//
//   channel   modport                   payload
//   stream    csvp_byte_if.sink         in_byte
//   records   csvp_result_if.source     kind, text_byte, four record numbers
//
// One byte is accepted per cycle while stream.ready is high; the parse state is updated at the
// accepting edge and any result is registered in the output or skid register.
// A two-entry result buffer (output register plus skid register) sets the rate:
// stream.ready drops only while the skid register holds an item.
// rst_n clears the parse state and the valid flags of both buffer entries asynchronously.
module csv_paper_record_parser import csvp_pkg::*; #(
    parameter int NUMBER_WIDTH = 32
) (
    input logic            clk,
    input logic            rst_n,
    csvp_byte_if.sink      stream,
    csvp_result_if.source  records
);

    field_t                  field_reg, field_next;
    logic                    in_quote_reg, in_quote_next;
    logic                    discarding_reg, discarding_next;
    logic [NUMBER_WIDTH-1:0] id_acc_reg, id_acc_next;
    logic [NUMBER_WIDTH-1:0] year_acc_reg, year_acc_next;
    logic [NUMBER_WIDTH-1:0] conf_acc_reg, conf_acc_next;
    logic [NUMBER_WIDTH-1:0] journal_acc_reg, journal_acc_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    skid_valid_reg, skid_valid_next;
    result_t                 out_reg, out_next;
    result_t                 skid_reg, skid_next;

    logic                    accept;
    logic                    take;
    logic                    fire;
    result_t                 result;
    logic [7:0]              c;
    logic                    is_digit;
    logic                    printable;
    logic [NUMBER_WIDTH-1:0] acc_sel;
    logic [NUMBER_WIDTH-1:0] acc_pushed;

    assign c         = stream.in_byte;
    assign accept    = stream.valid && stream.ready;
    assign take      = records.valid && records.ready;
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign printable = (c >= CH_SPACE) && (c <= CH_TILDE);

    always_comb
    begin
        unique case (field_reg)
            FIELD_ID:         acc_sel = id_acc_reg;
            FIELD_YEAR:       acc_sel = year_acc_reg;
            FIELD_CONFERENCE: acc_sel = conf_acc_reg;
            default:          acc_sel = journal_acc_reg;
        endcase
    end

    csvp_digit_acc #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_digit_acc (
        .acc      (acc_sel),
        .digit    (DIGIT_BITS'(c - CH_ZERO)),
        .acc_next (acc_pushed)
    );

    always_comb
    begin
        field_next       = field_reg;
        in_quote_next    = in_quote_reg;
        discarding_next  = discarding_reg;
        id_acc_next      = id_acc_reg;
        year_acc_next    = year_acc_reg;
        conf_acc_next    = conf_acc_reg;
        journal_acc_next = journal_acc_reg;
        fire             = 1'b0;
        result           = '0;

        if (accept)
        begin
            priority if (discarding_reg)
            begin
                if (c == CH_QUOTE)
                begin
                    in_quote_next = !in_quote_reg;
                end
                else if (!in_quote_reg && c == CH_NEWLINE)
                begin
                    field_next       = FIELD_ID;
                    in_quote_next    = 1'b0;
                    discarding_next  = 1'b0;
                    id_acc_next      = '0;
                    year_acc_next    = '0;
                    conf_acc_next    = '0;
                    journal_acc_next = '0;
                end
            end
            else if (!in_quote_reg && c == CH_COMMA)
            begin
                if (field_reg < FIELD_KEYWORDS)
                begin
                    field_next = field_reg + 3'd1;
                end
                else
                begin
                    discarding_next = 1'b1;
                    fire            = 1'b1;
                    result.kind     = KIND_ERROR;
                end
            end
            else if (c == CH_QUOTE)
            begin
                in_quote_next = !in_quote_reg;
            end
            else if (printable)
            begin
                unique case (field_reg)
                    FIELD_ID:
                    begin
                        if (is_digit)
                        begin
                            id_acc_next = acc_pushed;
                        end
                    end
                    FIELD_TITLE:
                    begin
                        fire             = 1'b1;
                        result.kind      = KIND_TITLE;
                        result.text_byte = c;
                    end
                    FIELD_YEAR:
                    begin
                        if (is_digit)
                        begin
                            year_acc_next = acc_pushed;
                        end
                    end
                    FIELD_CONFERENCE:
                    begin
                        if (is_digit)
                        begin
                            conf_acc_next = acc_pushed;
                        end
                    end
                    FIELD_JOURNAL:
                    begin
                        if (is_digit)
                        begin
                            journal_acc_next = acc_pushed;
                        end
                    end
                    default:
                    begin
                        fire             = 1'b1;
                        result.kind      = KIND_KEYWORD;
                        result.text_byte = c;
                    end
                endcase
            end
            else if (!in_quote_reg && c == CH_NEWLINE)
            begin
                fire                     = 1'b1;
                result.kind              = KIND_RECORD;
                result.record_id         = 32'(id_acc_reg);
                result.pub_year          = 32'(year_acc_reg);
                result.conference_number = 32'(conf_acc_reg);
                result.journal_number    = 32'(journal_acc_reg);
                field_next               = FIELD_ID;
                in_quote_next            = 1'b0;
                id_acc_next              = '0;
                year_acc_next            = '0;
                conf_acc_next            = '0;
                journal_acc_next         = '0;
            end
            else
            begin
                fire = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        priority if (take && skid_valid_reg)
        begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        else if (fire && (!out_valid_reg || take))
        begin
            out_next       = result;
            out_valid_next = 1'b1;
        end
        else if (fire)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg       <= FIELD_ID;
            in_quote_reg    <= 1'b0;
            discarding_reg  <= 1'b0;
            id_acc_reg      <= '0;
            year_acc_reg    <= '0;
            conf_acc_reg    <= '0;
            journal_acc_reg <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            field_reg       <= field_next;
            in_quote_reg    <= in_quote_next;
            discarding_reg  <= discarding_next;
            id_acc_reg      <= id_acc_next;
            year_acc_reg    <= year_acc_next;
            conf_acc_reg    <= conf_acc_next;
            journal_acc_reg <= journal_acc_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign stream.ready              = !skid_valid_reg;
    assign records.valid             = out_valid_reg;
    assign records.kind              = out_reg.kind;
    assign records.text_byte         = out_reg.text_byte;
    assign records.record_id         = out_reg.record_id;
    assign records.pub_year          = out_reg.pub_year;
    assign records.conference_number = out_reg.conference_number;
    assign records.journal_number    = out_reg.journal_number;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds an item while the output register is empty.");

    a_text_only_for_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == KIND_RECORD || out_reg.kind == KIND_ERROR))
        |-> (out_reg.text_byte == 8'd0))
        else $error("Record or error item carries a nonzero text byte.");

    a_error_starts_discard: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !discarding_reg && !in_quote_reg && c == CH_COMMA
         && field_reg >= FIELD_KEYWORDS) |=> discarding_reg)
        else $error("Extra comma did not start discarding.");

    a_field_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg <= FIELD_KEYWORDS)
        else $error("Field position moved past the keywords field.");

endmodule

FILE: design/csvp_digit_acc.sv
// Saturating decimal digit accumulator: acc * 10 + digit, clamped to all ones.
// Built from two shifts and two adds; depends on csvp_pkg for the digit width.
module csvp_digit_acc import csvp_pkg::*; #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic [NUMBER_WIDTH-1:0] acc,
    input  logic [DIGIT_BITS-1:0]   digit,
    output logic [NUMBER_WIDTH-1:0] acc_next
);

    localparam int WIDE = NUMBER_WIDTH + DIGIT_BITS;

    logic [WIDE-1:0] wide_sum;

    assign wide_sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                    + {{NUMBER_WIDTH{1'b0}}, digit};

    assign acc_next = (wide_sum[WIDE-1:NUMBER_WIDTH] != '0) ? '1
                                                             : wide_sum[NUMBER_WIDTH-1:0];

endmodule

FILE: tb/csv_paper_record_parser_tb.sv
// Self-checking testbench for the paper record parser: byte stream in, parse results out.
// Predicts each result from the accepted bytes and compares it field by field.
// Depends on csvp_pkg, csvp_if.sv and the parser RTL.
module csv_paper_record_parser_tb import csvp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUMBER_WIDTH = 32;
    localparam logic [63:0] NUMBER_MAX = (64'd1 << NUMBER_WIDTH) - 64'd1;
    localparam int RANDOM_ITEMS = 650;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 400000;

    class parse_tracker;
        field_t      position;
        bit          quoted;
        bit          skipping;
        logic [63:0] id_num;
        logic [63:0] year_num;
        logic [63:0] conf_num;
        logic [63:0] journal_num;
        result_t     awaited_results[$];
        int          errors;

        function new();
            clear_record();
            skipping = 1'b0;
            errors = 0;
        endfunction

        function void clear_record();
            position = FIELD_ID;
            quoted = 1'b0;
            id_num = '0;
            year_num = '0;
            conf_num = '0;
            journal_num = '0;
        endfunction

        function logic [63:0] add_digit(logic [63:0] acc, logic [7:0] c);
            logic [63:0] d;
            d = 64'(c - CH_ZERO);
            if (acc > (NUMBER_MAX - d) / RADIX)
                return NUMBER_MAX;
            return acc * RADIX + d;
        endfunction

        function void take_byte(logic [7:0] c);
            result_t      res;
            bit           emit;
            bit           digit;
            res = '0;
            emit = 1'b0;
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            if (skipping)
            begin
                if (c == CH_QUOTE)
                    quoted = !quoted;
                else if (!quoted && c == CH_NEWLINE)
                begin
                    clear_record();
                    skipping = 1'b0;
                end
            end
            else if (!quoted && c == CH_COMMA)
            begin
                if (position < FIELD_KEYWORDS)
                    position++;
                else
                begin
                    skipping = 1'b1;
                    res.kind = KIND_ERROR;
                    emit = 1'b1;
                end
            end
            else if (c == CH_QUOTE)
                quoted = !quoted;
            else if (c >= CH_SPACE && c <= CH_TILDE)
            begin
                case (position)
                    FIELD_ID:         if (digit) id_num = add_digit(id_num, c);
                    FIELD_YEAR:       if (digit) year_num = add_digit(year_num, c);
                    FIELD_CONFERENCE: if (digit) conf_num = add_digit(conf_num, c);
                    FIELD_JOURNAL:    if (digit) journal_num = add_digit(journal_num, c);
                    FIELD_TITLE:
                    begin
                        res.kind = KIND_TITLE;
                        res.text_byte = c;
                        emit = 1'b1;
                    end
                    default:
                    begin
                        res.kind = KIND_KEYWORD;
                        res.text_byte = c;
                        emit = 1'b1;
                    end
                endcase
            end
            else if (!quoted && c == CH_NEWLINE)
            begin
                res.kind = KIND_RECORD;
                res.record_id = id_num[31:0];
                res.pub_year = year_num[31:0];
                res.conference_number = conf_num[31:0];
                res.journal_number = journal_num[31:0];
                emit = 1'b1;
                clear_record();
            end
            if (emit)
                awaited_results = {awaited_results, res};
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result with kind %0d arrived while none was expected", got.kind);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(got.kind));
            check_field("text_byte", 32'(want.text_byte), 32'(got.text_byte));
            check_field("record_id", want.record_id, got.record_id);
            check_field("pub_year", want.pub_year, got.pub_year);
            check_field("conference_number", want.conference_number, got.conference_number);
            check_field("journal_number", want.journal_number, got.journal_number);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    csvp_byte_if   stream_ch();
    csvp_result_if records_ch();

    csv_paper_record_parser #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .stream(stream_ch),
        .records(records_ch)
    );

    parse_tracker tracker;
    logic [7:0]   rec_bytes[$];
    int           burst_left = 0;
    int           sent = 0;
    int           cycles = 0;

    always #10ns clk = ~clk;

    function automatic void queue_byte(input logic [7:0] b);
        rec_bytes = {rec_bytes, b};
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                stream_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        stream_ch.valid <= 1'b1;
        stream_ch.in_byte <= b;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        sent++;
        tracker.take_byte(b);
    endtask

    task automatic send_queued();
        int i;
        for (i = 0; i < rec_bytes.size(); i++)
            send_byte(rec_bytes[i]);
        rec_bytes.delete();
    endtask

    function automatic void add_number();
        int         digits;
        int         i;
        bit         wrapped;
        logic [7:0] junk;
        case ($urandom_range(0, 7))
            0: digits = 0;
            1: digits = $urandom_range(9, 14);
            default: digits = $urandom_range(1, 5);
        endcase
        wrapped = ($urandom_range(0, 5) == 0);
        if (wrapped)
            queue_byte(CH_QUOTE);
        if ($urandom_range(0, 5) == 0)
            queue_byte(($urandom_range(0, 1) != 0) ? "-" : " ");
        for (i = 0; i < digits; i++)
        begin
            if (i == 0 && digits == 10)
                queue_byte("4");
            else
                queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 15) == 0)
            begin
                junk = 8'($urandom);
                if (junk == CH_QUOTE || junk == CH_COMMA || junk == CH_NEWLINE)
                    junk = 8'h7F;
                queue_byte(junk);
            end
        end
        if (wrapped)
        begin
            queue_byte(CH_COMMA);
            queue_byte(CH_QUOTE);
        end
    endfunction

    function automatic void add_text();
        int         count;
        int         i;
        logic [7:0] c;
        count = $urandom_range(0, 6);
        for (i = 0; i < count; i++)
        begin
            c = 8'($urandom_range(32, 126));
            if (c == CH_QUOTE || c == CH_COMMA)
                c = "_";
            if ($urandom_range(0, 11) == 0)
                c = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(128, 255))
                                                : 8'($urandom_range(0, 9));
            queue_byte(c);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            queue_byte(CH_QUOTE);
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 2))
                    0: queue_byte(CH_COMMA);
                    1: queue_byte(CH_NEWLINE);
                    default:
                    begin
                        c = 8'($urandom_range(32, 126));
                        queue_byte((c == CH_QUOTE) ? 8'h27 : c);
                    end
                endcase
            end
            queue_byte(CH_QUOTE);
        end
    endfunction

    task automatic send_record();
        int shape;
        int fields;
        int f;
        shape = $urandom_range(0, 19);
        if (shape < 2)
        begin
            repeat ($urandom_range(1, 8))
                queue_byte(8'($urandom));
        end
        else
        begin
            fields = (shape == 4) ? $urandom_range(1, 5) : 6;
            for (f = 0; f < fields; f++)
            begin
                if (f > 0)
                    queue_byte(CH_COMMA);
                if (f == 1 || f == 5)
                    add_text();
                else
                    add_number();
            end
            if (shape == 2)
            begin
                queue_byte(CH_COMMA);
                add_text();
            end
            if (shape == 3)
            begin
                queue_byte(CH_QUOTE);
                add_text();
            end
            queue_byte(CH_NEWLINE);
        end
        send_queued();
    endtask

    initial
    begin
        int    i;
        string opening;
        opening = "-7,~\",\n\",2,,4, \n,,,,,,\"\n\"\n";
        tracker = new();
        rst_n = 1'b0;
        stream_ch.valid = 1'b0;
        stream_ch.in_byte = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h1F);
        queue_byte(8'h7F);
        for (i = 0; i < opening.len(); i++)
            queue_byte(opening[i]);
        send_queued();
        while (sent < RANDOM_ITEMS)
            send_record();
        stream_ch.valid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int      mode;
        int      tick;
        result_t got;
        records_ch.ready = 1'b0;
        mode = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (records_ch.valid && records_ch.ready)
            begin
                got.kind = records_ch.kind;
                got.text_byte = records_ch.text_byte;
                got.record_id = records_ch.record_id;
                got.pub_year = records_ch.pub_year;
                got.conference_number = records_ch.conference_number;
                got.journal_number = records_ch.journal_number;
                tracker.match_result(got);
            end
            tick++;
            if (tick % 96 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: records_ch.ready <= 1'b1;
                1: records_ch.ready <= ($urandom_range(0, 3) != 0);
                2: records_ch.ready <= (tick % 4 == 0);
                default: records_ch.ready <= (tick % 16 >= 10);
            endcase
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
